@@ hw/rtl/ed_pkg.sv @@
// Shared constants and types for the Euclidean distance block.
// Used by ed_front, ed_queue, ed_sqrt and euclidean_distance. No dependencies.
`timescale 1ns / 1ps

package ed_pkg;

   // element format and dimension limit
   localparam int MAX_DIM = 64;
   localparam int ELEM_W  = 16;
   localparam int IN_W    = 16;
   localparam int DIST_W  = 19;

   // accumulator sizing: MAX_DIM squares of an ELEM_W-bit magnitude
   localparam int SQ_W  = 2 * ELEM_W;
   localparam int SUM_W = $clog2(MAX_DIM) + 2 * ELEM_W;
   localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(longint'(MAX_DIM)
      * ((longint'(1) << ELEM_W) - 1) * ((longint'(1) << ELEM_W) - 1));

   // square root unit: one result bit per cycle
   localparam int ROOT_W = (SUM_W + 1) / 2;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 3;
   localparam int STEP_W = $clog2(ROOT_W);

   // sums waiting between front and back
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      logic               empty;
      logic [Q_CNT_W-1:0] count;
   } q_stat_type;

endpackage

@@ hw/rtl/euclidean_distance.sv @@
// Top level of the streaming Euclidean distance block.
// Depends on ed_pkg, ed_front, ed_queue and ed_sqrt.
//
//   channel  ports                                   direction  handshake
//   req      req_a_elem, req_b_elem, req_last        in         req_push / req_full
//   rsp      rsp_distance                            out        rsp_empty / rsp_pop
//
// One dimension is taken per cycle while req_full is low and passes through the difference
// and square registers into the running sum. The square root unit works on one distance
// at a time, one result bit per cycle, so pairs of points can be paced by the root rather
// than by the input.
// Up to four finished sums wait in the queue; req_full rises when queued sums plus
// last items still in the front pipe fill it.
// Synchronous reset clears the running sum, queue and all valid flags.
// A held rsp_pop low stalls the root unit; the front accumulates until req_full rises.
`timescale 1ns / 1ps

module euclidean_distance (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic signed [ed_pkg::IN_W-1:0]   req_a_elem,
   input  logic signed [ed_pkg::IN_W-1:0]   req_b_elem,
   input  logic                             req_last,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [ed_pkg::DIST_W-1:0]        rsp_distance
);

   ed_pkg::q_stat_type          q_stat;
   logic                        q_push, q_pop;
   logic [ed_pkg::SUM_W-1:0]    q_wdata, q_rdata;

   // accumulation
   ed_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_a_elem (req_a_elem),
      .req_b_elem (req_b_elem),
      .req_last   (req_last),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_data     (q_wdata)
   );

   // finished sums
   ed_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .stat      (q_stat)
   );

   // square root and result register
   ed_sqrt u_sqrt (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_stat.empty),
      .q_data       (q_rdata),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_distance (rsp_distance)
   );

endmodule

@@ hw/rtl/ed_front.sv @@
// Front end: difference, square and saturating accumulation, one item per cycle
// while req_full is low. Depends on ed_pkg; pushes finished sums into ed_queue.
`timescale 1ns / 1ps

module ed_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic signed [ed_pkg::IN_W-1:0]   req_a_elem,
   input  logic signed [ed_pkg::IN_W-1:0]   req_b_elem,
   input  logic                             req_last,
   input  ed_pkg::q_stat_type               q_stat,
   output logic                             q_push,
   output logic [ed_pkg::SUM_W-1:0]         q_data
);

   logic                           accept;
   logic [ed_pkg::ELEM_W:0]        diff_raw;
   logic [ed_pkg::ELEM_W-1:0]      diff_abs;
   logic                           s1_valid_ff, s1_last_ff;
   logic [ed_pkg::ELEM_W-1:0]      s1_diff_ff;
   logic                           s2_valid_ff, s2_last_ff;
   logic [ed_pkg::SQ_W-1:0]        s2_sq_ff;
   logic [ed_pkg::SUM_W-1:0]       sum_ff, sum_in;
   logic [ed_pkg::SUM_W:0]         total;
   logic [ed_pkg::SUM_W-1:0]       sum_sat;
   logic [ed_pkg::Q_CNT_W:0]       committed;

   // room check: queued sums plus last items still in the pipe
   assign committed = (ed_pkg::Q_CNT_W + 1)'(q_stat.count)
                    + (ed_pkg::Q_CNT_W + 1)'(s1_valid_ff & s1_last_ff)
                    + (ed_pkg::Q_CNT_W + 1)'(s2_valid_ff & s2_last_ff);
   assign req_full  = committed >= (ed_pkg::Q_CNT_W + 1)'(ed_pkg::Q_DEPTH);
   assign accept    = req_push & ~req_full;

   // stage 1: absolute difference of the sign-extended elements
   assign diff_raw = {req_a_elem[ed_pkg::ELEM_W-1], req_a_elem[ed_pkg::ELEM_W-1:0]}
                   - {req_b_elem[ed_pkg::ELEM_W-1], req_b_elem[ed_pkg::ELEM_W-1:0]};
   assign diff_abs = diff_raw[ed_pkg::ELEM_W] ? ed_pkg::ELEM_W'(-diff_raw)
                                              : diff_raw[ed_pkg::ELEM_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_diff_ff <= diff_abs;
      s1_last_ff <= req_last;
   end

   // stage 2: square
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_sq_ff   <= ed_pkg::SQ_W'(s1_diff_ff) * ed_pkg::SQ_W'(s1_diff_ff);
      s2_last_ff <= s1_last_ff;
   end

   // stage 3: saturating add; a last item hands the sum over and clears it
   assign total   = {1'b0, sum_ff} + (ed_pkg::SUM_W + 1)'(s2_sq_ff);
   assign sum_sat = (total > {1'b0, ed_pkg::SUM_MAX}) ? ed_pkg::SUM_MAX
                                                      : total[ed_pkg::SUM_W-1:0];

   always_comb begin
      sum_in = sum_ff;
      if (s2_valid_ff) begin
         sum_in = s2_last_ff ? '0 : sum_sat;
      end
   end

   assign q_push = s2_valid_ff & s2_last_ff;
   assign q_data = sum_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   // the room check must never promise more than the queue holds
   a_no_overcommit: assert property (@(posedge clock) disable iff (reset)
      committed <= (ed_pkg::Q_CNT_W + 1)'(ed_pkg::Q_DEPTH))
      else $error("front: more sums in flight than queue slots");

   // running sum never passes the saturation ceiling
   a_sum_bounded: assert property (@(posedge clock) disable iff (reset)
      sum_ff <= ed_pkg::SUM_MAX)
      else $error("front: running sum above ceiling");

endmodule

@@ hw/rtl/ed_queue.sv @@
// Short queue of finished sums between the front and back ends.
// Depends on ed_pkg.
`timescale 1ns / 1ps

module ed_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [ed_pkg::SUM_W-1:0]    push_data,
   input  logic                        pop,
   output logic [ed_pkg::SUM_W-1:0]    pop_data,
   output ed_pkg::q_stat_type          stat
);

   logic [ed_pkg::SUM_W-1:0]   mem [ed_pkg::Q_DEPTH];
   logic [ed_pkg::Q_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [ed_pkg::Q_CNT_W-1:0] count_ff, count_in;

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data   = mem[rd_ptr_ff];
   assign stat.empty = (count_ff == '0);
   assign stat.count = count_ff;

   // occupancy
   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // pointers wrap over the depth
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == ed_pkg::Q_PTR_W'(ed_pkg::Q_DEPTH - 1))
                         ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == ed_pkg::Q_PTR_W'(ed_pkg::Q_DEPTH - 1))
                         ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != ed_pkg::Q_CNT_W'(ed_pkg::Q_DEPTH)) || pop)
      else $error("queue: push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue: pop while empty");

endmodule

@@ hw/rtl/ed_sqrt.sv @@
// Back end: digit-by-digit floor square root, one result bit per cycle,
// followed by the result register. Depends on ed_pkg; fed from ed_queue.
`timescale 1ns / 1ps

module ed_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  logic [ed_pkg::SUM_W-1:0]    q_data,
   output logic                        q_pop,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [ed_pkg::DIST_W-1:0]   rsp_distance
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                 state_ff, state_in;
   logic [ed_pkg::RAD_W-1:0]   rad_ff;
   logic [ed_pkg::REM_W-1:0]   rem_ff, rem_sh, trial;
   logic [ed_pkg::ROOT_W-1:0]  root_ff;
   logic [ed_pkg::STEP_W-1:0]  step_ff;
   logic                       ge;
   logic                       out_valid_ff;
   logic [ed_pkg::DIST_W-1:0]  out_data_ff;
   logic                       out_free, out_load, out_take;

   // one restoring step: bring down two radicand bits, try root*4+1
   assign rem_sh = {rem_ff[ed_pkg::REM_W-3:0], rad_ff[ed_pkg::RAD_W-1 -: 2]};
   assign trial  = ed_pkg::REM_W'({root_ff, 2'b01});
   assign ge     = rem_sh >= trial;

   assign out_take = rsp_pop & out_valid_ff;
   assign out_free = ~out_valid_ff | out_take;
   assign out_load = (state_ff == ST_DONE) & out_free;
   assign q_pop    = (state_ff == ST_IDLE) & ~q_empty;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (!q_empty) state_in = ST_RUN;
         ST_RUN:  if (step_ff == '0) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath of the root iteration
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rad_ff  <= ed_pkg::RAD_W'(q_data);
         rem_ff  <= '0;
         root_ff <= '0;
         step_ff <= ed_pkg::STEP_W'(ed_pkg::ROOT_W - 1);
      end else if (state_ff == ST_RUN) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= ge ? rem_sh - trial : rem_sh;
         root_ff <= {root_ff[ed_pkg::ROOT_W-2:0], ge};
         step_ff <= step_ff - 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_load | (out_valid_ff & ~out_take);
      end
      if (out_load) begin
         out_data_ff <= root_ff[ed_pkg::DIST_W-1:0];
      end
   end

   assign rsp_empty    = ~out_valid_ff;
   assign rsp_distance = out_data_ff;

   // a finished root with a free result register shows up next cycle
   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> out_valid_ff)
      else $error("sqrt: finished root not delivered");

   // the queue is only read when the unit is idle
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == ST_RUN)
      else $error("sqrt: sum taken outside idle");

endmodule
